>>> src/pmc_pkg.sv
`timescale 1ns / 1ps

package pmc_pkg;

  localparam int NumDestDefault = 4;
  localparam int CapacityDefault = 16;
  localparam int FifoDepth = 2;

  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 32;
  localparam int ThresholdW = 5;
  localparam logic [ThresholdW-1:0] ThresholdReset = 5'd16;

  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_RANK = 1'b1;

  typedef enum logic [1:0] {
    CMD_ADD       = 2'd0,
    CMD_FLUSH     = 2'd1,
    CMD_FORCE     = 2'd2,
    CMD_FLUSH_ALL = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_WORD     = 2'd0,
    ST_ACCEPT   = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_NONE     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_ADD       = 2'd0,
    OP_FLUSH     = 2'd1,
    OP_FLUSH_ALL = 2'd2
  } op_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [1:0]  destination;
    logic [63:0] word;
    logic [15:0] tag;
  } item_t;

  typedef struct packed {
    status_e     status;
    logic [1:0]  dest_out;
    logic [63:0] data_out;
    logic [15:0] tag_out;
    logic [15:0] source_out;
    logic [4:0]  message_length;
    logic        last;
  } result_t;

  typedef struct packed {
    op_e         op;
    logic        force_send;
    logic        dest_ok;
    logic [1:0]  destination;
    logic [63:0] word;
    logic [15:0] tag;
  } op_t;

  typedef struct packed {
    logic [ThresholdW-1:0] threshold;
    logic [15:0]           own_rank;
  } cfg_t;

endpackage

>>> src/pmc_fifo.sv
`timescale 1ns / 1ps

module pmc_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> src/pmc_front.sv
`timescale 1ns / 1ps

module pmc_front #(
  parameter int NUM_DEST = 4
) (
  input  logic           push_i,
  input  pmc_pkg::item_t item_i,
  input  logic           q_full_i,
  output logic           q_push_o,
  output pmc_pkg::op_t   op_o
);

  import pmc_pkg::*;

  assign q_push_o = push_i && !q_full_i;

  always_comb begin
    op_o             = '0;
    op_o.destination = item_i.destination;
    op_o.word        = item_i.word;
    op_o.tag         = item_i.tag;
    op_o.dest_ok     = (32'(item_i.destination) < NUM_DEST);
    case (item_i.cmd)
      CMD_ADD: begin
        op_o.op = OP_ADD;
      end
      CMD_FLUSH: begin
        op_o.op = OP_FLUSH;
      end
      CMD_FORCE: begin
        op_o.op         = OP_FLUSH;
        op_o.force_send = 1'b1;
      end
      CMD_FLUSH_ALL: begin
        op_o.op = OP_FLUSH_ALL;
      end
      default: begin
        op_o.op = OP_ADD;
      end
    endcase
  end

endmodule

>>> src/pmc_back.sv
`timescale 1ns / 1ps

module pmc_back #(
  parameter int NUM_DEST = 4,
  parameter int CAPACITY = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pmc_pkg::cfg_t    cfg_i,
  input  logic             cmd_valid_i,
  input  pmc_pkg::op_t     cmd_i,
  output logic             cmd_pop_o,
  input  logic             out_full_i,
  output logic             out_push_o,
  output pmc_pkg::result_t result_o
);

  import pmc_pkg::*;

  localparam int DW = (NUM_DEST > 1) ? $clog2(NUM_DEST) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int TW = (CW > ThresholdW) ? CW : ThresholdW;
  localparam int Depth = NUM_DEST * CAPACITY;
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOOK  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;
  localparam logic [2:0] S_STAT  = 3'd5;

  logic [63:0]         word_mem_q [Depth];
  logic [CW-1:0]       fc_mem_q [NUM_DEST];

  logic [2:0]          state_q, state_d;
  logic [NUM_DEST-1:0] nz_q, nz_d;
  logic [DW-1:0]       cur_d_q, cur_d_d;
  logic [CW-1:0]       idx_q, idx_d;
  logic [CW-1:0]       len_q, len_d;
  op_t                 op_q, op_d;
  status_e             stat_q, stat_d;
  logic [1:0]          stat_dest_q, stat_dest_d;
  logic [CW-1:0]       fc_rd_q;
  logic                nz_rd_q;
  logic [63:0]         rd_data_q;

  logic [CW-1:0]       fill;
  logic                later_nz;
  logic                msg_end;
  logic                send;
  logic                fc_re, fc_we, wm_re, wm_we;
  logic [AW-1:0]       base_addr;
  logic [AW-1:0]       wr_addr;
  logic [AW-1:0]       rd_addr;

  assign fill      = nz_rd_q ? fc_rd_q : '0;
  assign msg_end   = (idx_q == len_q - CW'(1));
  assign base_addr = AW'(cur_d_q) * AW'(CAPACITY);
  assign wr_addr   = base_addr + AW'(fill);
  assign rd_addr   = base_addr + AW'(idx_q);
  assign send      = op_q.dest_ok && (fill != '0) &&
                     (op_q.force_send || (TW'(fill) >= TW'(cfg_i.threshold)));

  always_comb begin
    later_nz = 1'b0;
    for (int i = 0; i < NUM_DEST; i++) begin
      if (i > int'(cur_d_q)) begin
        later_nz = later_nz | nz_q[i];
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    nz_d        = nz_q;
    cur_d_d     = cur_d_q;
    idx_d       = idx_q;
    len_d       = len_q;
    op_d        = op_q;
    stat_d      = stat_q;
    stat_dest_d = stat_dest_q;
    cmd_pop_o   = 1'b0;
    out_push_o  = 1'b0;
    fc_re       = 1'b0;
    fc_we       = 1'b0;
    wm_re       = 1'b0;
    wm_we       = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          op_d      = cmd_i;
          if (cmd_i.op == OP_FLUSH_ALL) begin
            cur_d_d = '0;
            if (!(|nz_q)) begin
              stat_d      = ST_NONE;
              stat_dest_d = '0;
              state_d     = S_STAT;
            end else begin
              state_d = S_LOOK;
            end
          end else begin
            cur_d_d = cmd_i.dest_ok ? DW'(cmd_i.destination) : '0;
            state_d = S_LOOK;
          end
        end
      end
      S_LOOK: begin
        fc_re   = 1'b1;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        case (op_q.op)
          OP_ADD: begin
            stat_dest_d = op_q.destination;
            if (op_q.dest_ok && (fill < CW'(CAPACITY))) begin
              wm_we          = 1'b1;
              fc_we          = 1'b1;
              nz_d[cur_d_q]  = 1'b1;
              stat_d         = ST_ACCEPT;
            end else begin
              stat_d = ST_OVERFLOW;
            end
            state_d = S_STAT;
          end
          OP_FLUSH: begin
            if (send) begin
              idx_d   = '0;
              len_d   = fill;
              state_d = S_READ;
            end else begin
              stat_d      = ST_NONE;
              stat_dest_d = op_q.destination;
              state_d     = S_STAT;
            end
          end
          OP_FLUSH_ALL: begin
            if (fill != '0) begin
              idx_d   = '0;
              len_d   = fill;
              state_d = S_READ;
            end else begin
              cur_d_d = cur_d_q + DW'(1);
              state_d = S_LOOK;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_READ: begin
        wm_re   = 1'b1;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!out_full_i) begin
          out_push_o = 1'b1;
          if (msg_end) begin
            nz_d[cur_d_q] = 1'b0;
            if ((op_q.op == OP_FLUSH_ALL) && later_nz) begin
              cur_d_d = cur_d_q + DW'(1);
              state_d = S_LOOK;
            end else begin
              state_d = S_IDLE;
            end
          end else begin
            idx_d   = idx_q + CW'(1);
            state_d = S_READ;
          end
        end
      end
      S_STAT: begin
        if (!out_full_i) begin
          out_push_o = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    result_o = '0;
    if (state_q == S_EMIT) begin
      result_o.status         = ST_WORD;
      result_o.dest_out       = 2'(cur_d_q);
      result_o.data_out       = rd_data_q;
      result_o.tag_out        = op_q.tag;
      result_o.source_out     = cfg_i.own_rank;
      result_o.message_length = 5'(len_q);
      result_o.last           = msg_end && !((op_q.op == OP_FLUSH_ALL) && later_nz);
    end else begin
      result_o.status   = stat_q;
      result_o.dest_out = stat_dest_q;
      result_o.last     = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      nz_q    <= '0;
      cur_d_q <= '0;
      idx_q   <= '0;
      len_q   <= '0;
    end else begin
      state_q <= state_d;
      nz_q    <= nz_d;
      cur_d_q <= cur_d_d;
      idx_q   <= idx_d;
      len_q   <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    stat_q      <= stat_d;
    stat_dest_q <= stat_dest_d;
  end

  always_ff @(posedge clk_i) begin
    if (fc_we) begin
      fc_mem_q[cur_d_q] <= fill + CW'(1);
    end
    if (fc_re) begin
      fc_rd_q <= fc_mem_q[cur_d_q];
      nz_rd_q <= nz_q[cur_d_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wm_we) begin
      word_mem_q[wr_addr] <= op_q.word;
    end
    if (wm_re) begin
      rd_data_q <= word_mem_q[rd_addr];
    end
  end

  a_emit_in_message: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> (idx_q < len_q))
    else $error("Word index ran past the message length.");

  a_read_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> nz_q[cur_d_q])
    else $error("Reading words of a buffer that is marked empty.");

  a_walk_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_CHECK) && (op_q.op == OP_FLUSH_ALL)) |-> (|nz_q))
    else $error("Flush-all walk continued with every buffer empty.");

  a_add_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fc_we |=> nz_q[$past(cur_d_q)])
    else $error("An accepted word did not mark its buffer as nonempty.");

endmodule

>>> src/per_destination_message_coalescer_unit.sv
`timescale 1ns / 1ps
// Channel    Handshake                        Payload
// input      push / full                      item_i   (pmc_pkg::item_t)
// result     empty / pop                      result_o (pmc_pkg::result_t)
// config     psel, penable, pwrite, pready    paddr, pwdata, prdata
//
// An add passes the look, check and status states; a flush takes each word through read and emit
// states, since every word goes through the single registered read port of the word memory.
// Flush-all reads the fill count of each destination it walks past in the look and check states.
// Reset clears the fill counts at once through per-destination nonempty bits; no clearing pass.
// A two-entry queue on each side lets input and result sides stall on their own.

module per_destination_message_coalescer_unit #(
  parameter int NUM_DEST = pmc_pkg::NumDestDefault,
  parameter int CAPACITY = pmc_pkg::CapacityDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push,
  output logic                             full,
  input  pmc_pkg::item_t                   item_i,
  output logic                             empty,
  input  logic                             pop,
  output pmc_pkg::result_t                 result_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pmc_pkg::CfgAddrW-1:0]     paddr,
  input  logic [pmc_pkg::CfgDataW-1:0]     pwdata,
  output logic [pmc_pkg::CfgDataW-1:0]     prdata,
  output logic                             pready
);

  import pmc_pkg::*;

  localparam int OpW  = $bits(op_t);
  localparam int ResW = $bits(result_t);

  logic [ThresholdW-1:0] thr_q;
  logic [15:0]           rank_q;
  cfg_t                  cfg;
  logic                  cfg_we;

  logic                  q_push;
  logic                  q_full;
  logic                  q_empty;
  logic                  q_pop;
  op_t                   front_op;
  logic [OpW-1:0]        q_data;
  op_t                   back_op;
  logic                  out_push;
  logic                  out_full;
  result_t               back_res;
  logic [ResW-1:0]       out_data;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= ThresholdReset;
      rank_q <= '0;
    end else if (cfg_we) begin
      case (paddr[2])
        REG_THRESHOLD: thr_q  <= pwdata[ThresholdW-1:0];
        REG_RANK:      rank_q <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_THRESHOLD: prdata = CfgDataW'(thr_q);
      REG_RANK:      prdata = CfgDataW'(rank_q);
      default:       prdata = '0;
    endcase
  end

  assign cfg.threshold = thr_q;
  assign cfg.own_rank  = rank_q;

  pmc_front #(
    .NUM_DEST(NUM_DEST)
  ) u_front (
    .push_i  (push),
    .item_i  (item_i),
    .q_full_i(q_full),
    .q_push_o(q_push),
    .op_o    (front_op)
  );

  assign full = q_full;

  pmc_fifo #(
    .Width(OpW),
    .Depth(FifoDepth)
  ) u_cmd_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (front_op),
    .full_o (q_full),
    .pop_i  (q_pop),
    .data_o (q_data),
    .empty_o(q_empty)
  );

  assign back_op = q_data;

  pmc_back #(
    .NUM_DEST(NUM_DEST),
    .CAPACITY(CAPACITY)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .cmd_valid_i(!q_empty),
    .cmd_i      (back_op),
    .cmd_pop_o  (q_pop),
    .out_full_i (out_full),
    .out_push_o (out_push),
    .result_o   (back_res)
  );

  pmc_fifo #(
    .Width(ResW),
    .Depth(FifoDepth)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (out_push),
    .data_i (back_res),
    .full_o (out_full),
    .pop_i  (pop),
    .data_o (out_data),
    .empty_o(empty)
  );

  assign result_o = out_data;

endmodule
